[rtl/deq_pkg.sv]
// deq_pkg: shared types and constants for the double-ended queue unit
// no dependencies; imported by double_ended_queue_unit
`timescale 1ns / 1ps

package deq_pkg;

  // ring depth and derived widths
  localparam int DEPTH   = 16;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int WORD_W  = 32;
  localparam int OCC_W   = 5;
  localparam int MODE_W  = 2;
  localparam int STAT_W  = 2;

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_BACK  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_BACK   = 2'd3
  } mode_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

[rtl/double_ended_queue_unit.sv]
// double_ended_queue_unit: bounded deque of signed words kept in a ring memory
// depends on deq_pkg for depth, widths and operation/status codes
`timescale 1ns / 1ps

// Usage
//   Request channel (req_valid / req_stall): mode selects push front, push back,
//   pop front or pop back; push_value is the word stored on a push.
//   Response channel (rsp_valid / rsp_stall): pop_value is the removed word
//   (zero on pushes and failed pops), status reports ok, pop on empty or push on
//   full (the word is dropped), occupancy is the count after the operation.
//   A response is registered and appears in the cycle after its request is accepted.
//   Throughput: one request per cycle while req_stall is low; the front index and
//   count update in the accept cycle, so a request may follow in the next cycle,
//   and the single read/write memory port serves one access per request.
//   A pop reads the ring memory at the accept edge; its registered read data
//   feeds pop_value directly, alongside the response registers.
//   Stall: while a response is held under rsp_stall, req_stall is raised and no
//   request is taken, so the response and its read data stay unchanged.
//   Reset: front index and count clear to zero, the queue is empty and no
//   response is pending; memory contents are not cleared (only occupied entries
//   are ever read).
module double_ended_queue_unit
  import deq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic [MODE_W-1:0]        mode,
  input  logic signed [WORD_W-1:0] push_value,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output logic signed [WORD_W-1:0] pop_value,
  output logic [STAT_W-1:0]        status,
  output logic [OCC_W-1:0]         occupancy
);

  // ring pointer state
  logic [ADDR_W-1:0] front;
  logic [ADDR_W-1:0] front_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;

  // response stage
  logic              rsp_pop;
  logic              rsp_pop_next;
  status_t           rsp_status;
  status_t           rsp_status_next;
  logic [CNT_W-1:0]  rsp_count;

  // memory port
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data;
  logic              wr_en;
  logic              rd_en;
  logic [ADDR_W-1:0] addr;

  logic              accept;
  logic              is_full;
  logic              is_empty;
  mode_t             op;

  // ring positions, kept below twice the depth before wrapping
  logic [ADDR_W:0]   sum_back;
  logic [ADDR_W:0]   sum_last;
  logic [ADDR_W-1:0] pos_back;
  logic [ADDR_W-1:0] pos_last;
  logic [ADDR_W-1:0] pos_before;
  logic [ADDR_W-1:0] pos_after;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign op        = mode_t'(mode);
  assign is_full   = (count == CNT_W'(DEPTH));
  assign is_empty  = (count == '0);

  // ring arithmetic with wrap in both directions
  always_comb begin
    sum_back   = (ADDR_W+1)'(front) + (ADDR_W+1)'(count);
    sum_last   = sum_back - (ADDR_W+1)'(1);
    pos_back   = (sum_back >= (ADDR_W+1)'(DEPTH)) ?
                 ADDR_W'(sum_back - (ADDR_W+1)'(DEPTH)) : ADDR_W'(sum_back);
    pos_last   = (sum_last >= (ADDR_W+1)'(DEPTH)) ?
                 ADDR_W'(sum_last - (ADDR_W+1)'(DEPTH)) : ADDR_W'(sum_last);
    pos_before = (front == '0) ? ADDR_W'(DEPTH - 1) : front - ADDR_W'(1);
    pos_after  = (front == ADDR_W'(DEPTH - 1)) ? '0 : front + ADDR_W'(1);
  end

  // operation decode: pointer update, memory access and response fields
  always_comb begin
    front_next      = front;
    count_next      = count;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    addr            = front;
    rsp_pop_next    = 1'b0;
    rsp_status_next = ST_OK;
    case (op)
      MODE_PUSH_FRONT: begin
        if (is_full) begin
          rsp_status_next = ST_FULL;
        end else begin
          front_next = pos_before;
          count_next = count + CNT_W'(1);
          addr       = pos_before;
          wr_en      = accept;
        end
      end
      MODE_PUSH_BACK: begin
        if (is_full) begin
          rsp_status_next = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
          addr       = pos_back;
          wr_en      = accept;
        end
      end
      MODE_POP_FRONT: begin
        if (is_empty) begin
          rsp_status_next = ST_EMPTY;
        end else begin
          front_next   = pos_after;
          count_next   = count - CNT_W'(1);
          addr         = front;
          rd_en        = accept;
          rsp_pop_next = 1'b1;
        end
      end
      default: begin
        if (is_empty) begin
          rsp_status_next = ST_EMPTY;
        end else begin
          count_next   = count - CNT_W'(1);
          addr         = pos_last;
          rd_en        = accept;
          rsp_pop_next = 1'b1;
        end
      end
    endcase
  end

  // pointer and response control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        front <= front_next;
        count <= count_next;
      end
      if (!req_stall) begin
        rsp_valid <= req_valid;
      end
    end
  end

  // response payload, held while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_pop    <= rsp_pop_next;
      rsp_status <= rsp_status_next;
      rsp_count  <= count_next;
    end
  end

  // ring memory, one access per request
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

  assign pop_value = rsp_pop ? $signed(rd_data) : '0;
  assign status    = rsp_status;
  assign occupancy = OCC_W'(rsp_count);

  // count never passes the ring depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("deque count exceeds depth");

  // an accepted request always yields a response in the next cycle
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("response missing after accepted request");

  // a pop on an empty queue reports empty and leaves the count at zero
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (accept && is_empty && mode[1]) |=> (rsp_status == ST_EMPTY) && (count == '0))
    else $error("pop on empty queue misreported");

  // a push on a full queue is dropped
  a_full_push: assert property (@(posedge clk) disable iff (rst)
    (accept && is_full && !mode[1]) |-> !wr_en)
    else $error("push on full queue written to memory");

  // only successful pops carry a word
  a_pop_flag: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_pop) |-> (rsp_status == ST_OK))
    else $error("popped word with failing status");

endmodule

[tb/testbench.sv]
// testbench: self-checking bench for double_ended_queue_unit, random and directed requests
// depends on deq_pkg and the double_ended_queue_unit rtl; mirrors the deque state to predict
`timescale 1ns / 1ps

module testbench;
  import deq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_PRINTS  = 100;

  typedef struct {
    logic signed [WORD_W-1:0] value;
    status_t                  st;
    logic [OCC_W-1:0]         occ;
  } deq_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     req_valid = 1'b0;
  logic                     req_stall;
  logic [MODE_W-1:0]        mode = MODE_PUSH_FRONT;
  logic signed [WORD_W-1:0] push_value = '0;
  logic                     rsp_valid;
  logic                     rsp_stall = 1'b0;
  logic signed [WORD_W-1:0] pop_value;
  logic [STAT_W-1:0]        status;
  logic [OCC_W-1:0]         occupancy;

  // shadow copy of the deque
  logic signed [WORD_W-1:0] shadow_ring [DEPTH];
  int                       shadow_front = 0;
  int                       shadow_count = 0;

  deq_result_t pending_results [$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_trigger = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  double_ended_queue_unit dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .mode       (mode),
    .push_value (push_value),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .pop_value  (pop_value),
    .status     (status),
    .occupancy  (occupancy)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: random stall, or a long hold-off when triggered
  always @(posedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic report_mismatch(string msg);
    if (error_count < MAX_PRINTS)
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // apply one request to the shadow deque and return its response
  function automatic deq_result_t apply_deq_op(mode_t op, logic signed [WORD_W-1:0] word);
    deq_result_t res;
    int slot;
    res.value = '0;
    res.st = ST_OK;
    case (op)
      MODE_PUSH_FRONT: begin
        if (shadow_count >= DEPTH) begin
          res.st = ST_FULL;
        end else begin
          shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
          shadow_ring[shadow_front] = word;
          shadow_count++;
        end
      end
      MODE_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          res.st = ST_FULL;
        end else begin
          slot = (shadow_front + shadow_count) % DEPTH;
          shadow_ring[slot] = word;
          shadow_count++;
        end
      end
      MODE_POP_FRONT: begin
        if (shadow_count == 0) begin
          res.st = ST_EMPTY;
        end else begin
          res.value = shadow_ring[shadow_front];
          shadow_front = (shadow_front + 1) % DEPTH;
          shadow_count--;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          res.st = ST_EMPTY;
        end else begin
          slot = (shadow_front + shadow_count - 1) % DEPTH;
          res.value = shadow_ring[slot];
          shadow_count--;
        end
      end
    endcase
    res.occ = OCC_W'(shadow_count);
    return res;
  endfunction

  // predict on accepted requests, check accepted responses
  always @(posedge clk) begin
    deq_result_t want;
    if (!rst) begin
      if (req_valid && !req_stall)
        pending_results.push_back(apply_deq_op(mode_t'(mode), push_value));
      if (rsp_valid && !rsp_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          want = pending_results.pop_front();
          if (pop_value !== want.value)
            report_mismatch($sformatf("pop_value got %0d want %0d", pop_value, want.value));
          if (status !== want.st)
            report_mismatch($sformatf("status got %0d want %0d", status, want.st));
          if (occupancy !== want.occ)
            report_mismatch($sformatf("occupancy got %0d want %0d", occupancy, want.occ));
        end
      end
    end
  end

  // offer one request, with optional idle cycles first, and wait until taken
  task automatic send_request(mode_t op, logic signed [WORD_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid  <= 1'b1;
    mode       <= op;
    push_value <= word;
    do @(posedge clk); while (!(req_valid && !req_stall));
  endtask

  // stop offering and wait for every outstanding response
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(7))
      0: return {1'b1, {(WORD_W-1){1'b0}}};
      1: return {1'b0, {(WORD_W-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // empty pops, extreme words, last-word pops from both ends, full pushes
  task automatic test_directed_cases();
    send_idle_pct = 0;
    stall_pct <= 0;
    send_request(MODE_POP_FRONT, 32'sd7);
    send_request(MODE_POP_BACK, -32'sd7);
    send_request(MODE_PUSH_FRONT, {1'b1, {(WORD_W-1){1'b0}}});
    send_request(MODE_PUSH_BACK, {1'b0, {(WORD_W-1){1'b1}}});
    send_request(MODE_POP_FRONT, '0);
    send_request(MODE_POP_BACK, '1);
    send_request(MODE_PUSH_BACK, '0);
    send_request(MODE_POP_FRONT, '0);
    // fill from both ends so the ring wraps both ways
    for (int i = 0; i < DEPTH; i++) begin
      if (i % 2 == 0)
        send_request(MODE_PUSH_FRONT, (i % 4 == 0) ? '1 : pick_word());
      else
        send_request(MODE_PUSH_BACK, (i % 4 == 1) ? '0 : pick_word());
    end
    send_request(MODE_PUSH_FRONT, 32'sh5a5a_a5a5);
    send_request(MODE_PUSH_BACK, -32'sh5a5a_a5a5);
  endtask

  // random operations in bursts biased toward push, pop or balanced
  task automatic test_random_mix(int count, int idle_pct, int rsp_pct);
    int push_pct;
    mode_t op;
    push_pct = 50;
    send_idle_pct = idle_pct;
    stall_pct <= rsp_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 24 == 0) begin
        case ($urandom_range(2))
          0: push_pct = 15;
          1: push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      if ($urandom_range(99) < push_pct)
        op = $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
      else
        op = $urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT;
      send_request(op, pick_word());
    end
  endtask

  // long receiver hold-off while requests keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct <= 0;
    hold_trigger <= hold_trigger + 1;
    for (int i = 0; i < 24; i++)
      send_request(mode_t'($urandom_range(3)), pick_word());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    wait_drained();
    test_random_mix(350, 0, 0);
    wait_drained();
    test_backpressure();
    wait_drained();
    test_random_mix(350, 63, 0);
    wait_drained();
    test_random_mix(350, 0, 63);
    wait_drained();
    test_random_mix(350, 13, 13);
    wait_drained();

    // responses are registered; wait for stray responses before reporting
    stall_pct <= 0;
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
